[hdl/kmrp_pkg.sv]
// Shared types and constants for the Metadata v1 response parser.
// Used by every module of the parser; depends on nothing else.
`default_nettype none

package kmrp_pkg;

    // Width of the frame-length fields, and the default frame-length limit.
    localparam int LEN_W         = 15;
    localparam int MAX_FRAME_DEF = 16384;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SMALL  = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] brokers_seen;
        logic signed [31:0] topics_seen;
    } t_out_word;

endpackage

`default_nettype wire

[hdl/kmrp_in_reg.sv]
// Input register of the parser: holds one incoming word until the walker takes it.
// Depends on kmrp_pkg.
`default_nettype none

module kmrp_in_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  kmrp_pkg::t_in_word i_data,
    output logic               o_stall,
    output logic               o_item_valid,
    output kmrp_pkg::t_in_word o_item,
    input  wire                i_item_take
);
    import kmrp_pkg::*;

    logic     r_valid;
    t_in_word r_data;

    // A held word that is taken this cycle frees the register for the next one.
    assign o_stall      = r_valid && !i_item_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_item_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[hdl/kmrp_walker.sv]
// Parse state, one-byte-per-cycle next-state logic and result register; end bytes wait on a stalled result.
// Depends on kmrp_pkg.
`default_nettype none

module kmrp_walker #(
    parameter int MAX_FRAME = kmrp_pkg::MAX_FRAME_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  kmrp_pkg::t_in_word  i_item,
    output logic                o_item_take,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    output kmrp_pkg::t_out_word o_out_data
);
    import kmrp_pkg::*;

    localparam logic [3:0] PH_SIZE   = 4'd0;
    localparam logic [3:0] PH_CORR   = 4'd1;
    localparam logic [3:0] PH_BCOUNT = 4'd2;
    localparam logic [3:0] PH_NODE   = 4'd3;
    localparam logic [3:0] PH_HLEN   = 4'd4;
    localparam logic [3:0] PH_HOST   = 4'd5;
    localparam logic [3:0] PH_PORT   = 4'd6;
    localparam logic [3:0] PH_RLEN   = 4'd7;
    localparam logic [3:0] PH_RACK   = 4'd8;
    localparam logic [3:0] PH_CTRL   = 4'd9;
    localparam logic [3:0] PH_TOPIC  = 4'd10;
    localparam logic [3:0] PH_TAIL   = 4'd11;
    localparam logic [3:0] PH_BAD    = 4'd12;

    localparam logic [31:0] MaxFrameW = 32'(MAX_FRAME);

    logic [3:0]       r_phase,        n_phase;
    logic [LEN_W-1:0] r_frame_len,    n_frame_len;
    logic [LEN_W-1:0] r_bytes_taken,  n_bytes_taken;
    logic [31:0]      r_word,         n_word;
    logic [1:0]       r_biw,          n_biw;
    logic [30:0]      r_brokers_left, n_brokers_left;
    logic [LEN_W-1:0] r_skip_left,    n_skip_left;
    logic [31:0]      r_broker_total, n_broker_total;
    logic [31:0]      r_topic_total,  n_topic_total;

    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    logic [LEN_W-1:0] taken_inc;
    logic [LEN_W-1:0] left;
    logic [31:0]      shifted;
    logic [LEN_W-1:0] dec_skip;
    logic [15:0]      v;
    logic             do_next;
    logic             do_begin;
    logic [30:0]      bl;
    logic             out_free;

    // Only a word that ends the stream needs room in the result register.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_item_take = i_item_valid && (!i_item.end_of_stream || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase        = r_phase;
        n_frame_len    = r_frame_len;
        n_bytes_taken  = r_bytes_taken;
        n_word         = r_word;
        n_biw          = r_biw;
        n_brokers_left = r_brokers_left;
        n_skip_left    = r_skip_left;
        n_broker_total = r_broker_total;
        n_topic_total  = r_topic_total;
        n_out          = '0;

        taken_inc = r_bytes_taken + 1'b1;
        left      = r_frame_len - taken_inc;
        shifted   = {r_word[23:0], i_item.data_byte};
        dec_skip  = (r_skip_left == '0) ? '0 : r_skip_left - 1'b1;
        v         = shifted[15:0];
        do_next   = 1'b0;
        do_begin  = 1'b0;
        bl        = r_brokers_left;

        if (r_phase == PH_SIZE) begin
            n_word = shifted;
            if (r_biw != 2'd3) begin
                n_biw = r_biw + 1'b1;
            end else begin
                n_biw = 2'd0;
                if (shifted[31] || shifted < 32'd4 || shifted > MaxFrameW) begin
                    n_phase = PH_BAD;
                end else begin
                    n_frame_len   = shifted[LEN_W-1:0];
                    n_bytes_taken = '0;
                    n_phase       = PH_CORR;
                    n_skip_left   = LEN_W'(4);
                end
            end
        end else if (r_phase != PH_BAD && r_bytes_taken < r_frame_len) begin
            n_bytes_taken = taken_inc;
            unique case (r_phase) inside
                PH_CORR, PH_NODE, PH_HOST, PH_PORT, PH_RACK, PH_CTRL: begin
                    n_skip_left = dec_skip;
                    if (dec_skip == '0) begin
                        unique case (r_phase)
                            PH_CORR: begin
                                if (left >= LEN_W'(4)) begin
                                    n_phase = PH_BCOUNT;
                                    n_word  = '0;
                                    n_biw   = 2'd0;
                                end else begin
                                    n_phase = PH_TAIL;
                                end
                            end
                            PH_NODE: begin
                                if (left < LEN_W'(2)) begin
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_phase = PH_HLEN;
                                    n_word  = '0;
                                    n_biw   = 2'd0;
                                end
                            end
                            PH_HOST: begin
                                if (left < LEN_W'(4)) begin
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_phase     = PH_PORT;
                                    n_skip_left = LEN_W'(4);
                                end
                            end
                            PH_PORT: begin
                                if (left < LEN_W'(2)) begin
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_phase = PH_RLEN;
                                    n_word  = '0;
                                    n_biw   = 2'd0;
                                end
                            end
                            PH_RACK: begin
                                do_next = 1'b1;
                            end
                            default: begin
                                if (left >= LEN_W'(4)) begin
                                    n_phase = PH_TOPIC;
                                    n_word  = '0;
                                    n_biw   = 2'd0;
                                end else begin
                                    n_phase = PH_TAIL;
                                end
                            end
                        endcase
                    end
                end
                PH_BCOUNT, PH_TOPIC: begin
                    n_word = shifted;
                    if (r_biw != 2'd3) begin
                        n_biw = r_biw + 1'b1;
                    end else begin
                        n_biw = 2'd0;
                        if (r_phase == PH_TOPIC) begin
                            n_topic_total = shifted;
                            n_phase       = PH_TAIL;
                        end else begin
                            n_broker_total = shifted;
                            // A negative broker count walks no records.
                            bl             = shifted[31] ? '0 : shifted[30:0];
                            n_brokers_left = bl;
                            do_begin       = 1'b1;
                        end
                    end
                end
                PH_HLEN, PH_RLEN: begin
                    n_word = shifted;
                    if (r_biw != 2'd1) begin
                        n_biw = r_biw + 1'b1;
                    end else begin
                        n_biw = 2'd0;
                        if (r_phase == PH_HLEN) begin
                            if (v[15] || v[LEN_W-1:0] > left) begin
                                n_phase = PH_TAIL;
                            end else if (v == 16'd0) begin
                                if (left < LEN_W'(4)) begin
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_phase     = PH_PORT;
                                    n_skip_left = LEN_W'(4);
                                end
                            end else begin
                                n_phase     = PH_HOST;
                                n_skip_left = v[LEN_W-1:0];
                            end
                        end else begin
                            // A null, empty or oversized rack is not skipped.
                            if (!v[15] && v != 16'd0 && v[LEN_W-1:0] <= left) begin
                                n_phase     = PH_RACK;
                                n_skip_left = v[LEN_W-1:0];
                            end else begin
                                do_next = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_TAIL;
                end
            endcase
        end

        if (do_next) begin
            bl             = (r_brokers_left != '0) ? r_brokers_left - 1'b1 : r_brokers_left;
            n_brokers_left = bl;
            do_begin       = 1'b1;
        end

        if (do_begin) begin
            if (bl == '0 || left == '0) begin
                if (left >= LEN_W'(4)) begin
                    n_phase     = PH_CTRL;
                    n_skip_left = LEN_W'(4);
                end else begin
                    n_phase = PH_TAIL;
                end
            end else if (left < LEN_W'(4)) begin
                n_phase = PH_TAIL;
            end else begin
                n_phase     = PH_NODE;
                n_skip_left = LEN_W'(4);
            end
        end

        if (i_item.end_of_stream) begin
            if (n_phase == PH_SIZE) begin
                n_out.status = ST_TRUNC;
            end else if (n_phase == PH_BAD) begin
                n_out.status = ST_BADLEN;
            end else if (n_bytes_taken < n_frame_len) begin
                n_out.status = ST_TRUNC;
            end else if (n_frame_len <= LEN_W'(8)) begin
                n_out.status = ST_SMALL;
            end else begin
                n_out.status = ST_OK;
            end
            if (n_out.status == ST_OK) begin
                n_out.brokers_seen = n_broker_total;
                n_out.topics_seen  = n_topic_total;
            end
            // The end mark returns the parser to its idle state.
            n_phase        = PH_SIZE;
            n_frame_len    = '0;
            n_bytes_taken  = '0;
            n_word         = '0;
            n_biw          = 2'd0;
            n_brokers_left = '0;
            n_skip_left    = '0;
            n_broker_total = '0;
            n_topic_total  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_frame_len    <= '0;
            r_bytes_taken  <= '0;
            r_word         <= '0;
            r_biw          <= 2'd0;
            r_brokers_left <= '0;
            r_skip_left    <= '0;
            r_broker_total <= '0;
            r_topic_total  <= '0;
        end else if (o_item_take) begin
            r_phase        <= n_phase;
            r_frame_len    <= n_frame_len;
            r_bytes_taken  <= n_bytes_taken;
            r_word         <= n_word;
            r_biw          <= n_biw;
            r_brokers_left <= n_brokers_left;
            r_skip_left    <= n_skip_left;
            r_broker_total <= n_broker_total;
            r_topic_total  <= n_topic_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_item_take && i_item.end_of_stream) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && i_item.end_of_stream) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[hdl/kafka_metadata_response_parser_unit.sv]
// Top level of the Metadata v1 response parser: input register and byte walker.
// Depends on kmrp_pkg, kmrp_in_reg and kmrp_walker.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall    | data_byte, end_of_stream
//   out     | output    | o_out_valid / i_out_stall  | status, brokers_seen, topics_seen
//
// One byte is accepted per cycle while the walker takes them; an end-marked byte sets the result register.
// The walker's next-state logic sits between the input register and the state/result registers.
// Reset is synchronous and active low; it returns the parser to waiting for a size prefix.
// A stalled result blocks only an end-marked byte; other bytes keep flowing past it.
`default_nettype none

module kafka_metadata_response_parser_unit #(
    parameter int MAX_FRAME = kmrp_pkg::MAX_FRAME_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  kmrp_pkg::t_in_word  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output kmrp_pkg::t_out_word o_out_data,
    input  wire                 i_out_stall
);
    import kmrp_pkg::*;

    logic     item_valid;
    t_in_word item;
    logic     item_take;

    kmrp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_stall      (o_in_stall),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    kmrp_walker #(
        .MAX_FRAME (MAX_FRAME)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
